// ===== design/adac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adac_pkg: shared types and constants
// Beat layouts, configuration bundle, register indexes and cause codes for the
// altitude descent activation controller.
// ----------------------------------------------------------------------------
package adac_pkg;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic signed [23:0] altitude_dm;
    logic        [2:0]  fix_type;
    logic               values_finite;
  } in_t;

  typedef struct packed {
    logic        activated;
    logic [1:0]  activation_cause;
    logic        armed;
    logic        descending;
    logic [19:0] secs_left;
  } out_t;

  typedef struct packed {
    logic [19:0] failsafe_seconds;
    logic [19:0] descent_delay_seconds;
    logic [19:0] arm_gain_dm;
    logic [2:0]  fix_code_3d;
  } cfg_t;

  // configuration register indexes
  localparam logic [1:0] REG_FAILSAFE = 2'd0;
  localparam logic [1:0] REG_DELAY    = 2'd1;
  localparam logic [1:0] REG_ARM_GAIN = 2'd2;
  localparam logic [1:0] REG_FIX_CODE = 2'd3;

  localparam logic [19:0] FAILSAFE_RST = 20'd3600;
  localparam logic [19:0] DELAY_RST    = 20'd600;
  localparam logic [19:0] ARM_GAIN_RST = 20'd5000;
  localparam logic [2:0]  FIX_CODE_RST = 3'd3;

  // beat kinds
  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // activation causes
  localparam logic [1:0] CAUSE_NONE     = 2'd0;
  localparam logic [1:0] CAUSE_DESCENT  = 2'd1;
  localparam logic [1:0] CAUSE_FAILSAFE = 2'd2;

  // position limits: 1e-7 degree and decimetre units
  localparam logic signed [31:0] LAT_MAX = 32'sd900000000;
  localparam logic signed [31:0] LAT_MIN = -32'sd900000000;
  localparam logic signed [31:0] LON_MAX = 32'sd1800000000;
  localparam logic signed [31:0] LON_MIN = -32'sd1800000000;
  localparam logic signed [23:0] ALT_LOW_DM  = -24'sd10000;
  localparam logic signed [23:0] ALT_HIGH_DM = 24'sd1000000;

endpackage

// ===== design/altitude_descent_activation_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// altitude_descent_activation_controller: top level
// An accepted beat is held in the input register; the flight state update then
// forms its result, which loads into the result register when that slot is free
// or draining. Throughput: one beat per cycle while out_ready does not stall it.
// Reset (rst_n, synchronous, active low) clears the flight state and valid
// flags and loads the default timeouts, arm gain and 3D fix code.
// ----------------------------------------------------------------------------
module altitude_descent_activation_controller #(
  parameter int TIME_BITS = 21
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  adac_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output adac_pkg::out_t  out_data,
  input  logic            cfg_wr_en,
  input  logic [1:0]      cfg_index,
  input  logic [19:0]     cfg_wdata
);

  adac_pkg::cfg_t  cfg_r;
  adac_pkg::in_t   item_r;
  logic            item_v_r;
  adac_pkg::out_t  out_data_r;
  logic            out_v_r;
  adac_pkg::out_t  res;
  logic            rpt_ok;
  logic            step;

  // advance the held beat whenever the result slot is free or draining
  assign step     = item_v_r && (!out_v_r || out_ready);
  assign in_ready = !item_v_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.failsafe_seconds      <= adac_pkg::FAILSAFE_RST;
      cfg_r.descent_delay_seconds <= adac_pkg::DELAY_RST;
      cfg_r.arm_gain_dm           <= adac_pkg::ARM_GAIN_RST;
      cfg_r.fix_code_3d           <= adac_pkg::FIX_CODE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        adac_pkg::REG_FAILSAFE: cfg_r.failsafe_seconds      <= cfg_wdata;
        adac_pkg::REG_DELAY:    cfg_r.descent_delay_seconds <= cfg_wdata;
        adac_pkg::REG_ARM_GAIN: cfg_r.arm_gain_dm           <= cfg_wdata;
        adac_pkg::REG_FIX_CODE: cfg_r.fix_code_3d           <= cfg_wdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_ready) begin
      item_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data_r <= res;
    end
  end

  adac_chk u_chk (
    .item        (item_r),
    .fix_code_3d (cfg_r.fix_code_3d),
    .rpt_ok      (rpt_ok)
  );

  adac_ctrl #(
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item_r),
    .rpt_ok (rpt_ok),
    .cfg    (cfg_r),
    .res    (res)
  );

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/adac_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adac_chk: position report validity check
// Flags a report whose fix, finiteness and coordinate ranges are all good.
// ----------------------------------------------------------------------------
module adac_chk (
  input  adac_pkg::in_t  item,
  input  logic [2:0]     fix_code_3d,
  output logic           rpt_ok
);

  logic lat_ok;
  logic lon_ok;
  logic alt_ok;

  assign lat_ok = (item.latitude >= adac_pkg::LAT_MIN) &&
                  (item.latitude <= adac_pkg::LAT_MAX);
  assign lon_ok = (item.longitude >= adac_pkg::LON_MIN) &&
                  (item.longitude <= adac_pkg::LON_MAX);
  // both altitude bounds are strict
  assign alt_ok = (item.altitude_dm > adac_pkg::ALT_LOW_DM) &&
                  (item.altitude_dm < adac_pkg::ALT_HIGH_DM);

  assign rpt_ok = (item.fix_type == fix_code_3d) && item.values_finite &&
                  lat_ok && lon_ok && alt_ok;

endmodule

// ===== design/adac_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adac_ctrl: flight state and activation logic
// Holds base altitude, arm and descent flags, the two elapsed-second counters
// and the latched cause; updates them for one beat and forms its result.
// ----------------------------------------------------------------------------
module adac_ctrl #(
  parameter int TIME_BITS = 21
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  adac_pkg::in_t   item,
  input  logic            rpt_ok,
  input  adac_pkg::cfg_t  cfg,
  output adac_pkg::out_t  res
);

  localparam int CW = (TIME_BITS > 20) ? TIME_BITS : 20;
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  logic                  seen_r, seen_nxt;
  logic                  armed_r, armed_nxt;
  logic                  desc_r, desc_nxt;
  logic signed [23:0]    base_r, base_nxt;
  logic [TIME_BITS-1:0]  good_r, good_nxt;
  logic [TIME_BITS-1:0]  dsc_r, dsc_nxt;
  logic [1:0]            cause_r, cause_nxt;

  logic [TIME_BITS-1:0]  good_inc;
  logic [TIME_BITS-1:0]  dsc_inc;
  logic signed [24:0]    above;
  logic                  climb_ok;
  logic [CW-1:0]         rem_full;

  assign good_inc = (good_r == TMAX) ? good_r : good_r + TIME_BITS'(1);
  assign dsc_inc  = (dsc_r == TMAX) ? dsc_r : dsc_r + TIME_BITS'(1);

  always_comb begin
    seen_nxt  = seen_r;
    armed_nxt = armed_r;
    desc_nxt  = desc_r;
    base_nxt  = base_r;
    good_nxt  = good_r;
    dsc_nxt   = dsc_r;
    cause_nxt = cause_r;
    above     = '0;
    climb_ok  = 1'b0;
    rem_full  = '0;

    if (cause_r == adac_pkg::CAUSE_NONE) begin
      if (item.kind == adac_pkg::KIND_TICK) begin
        good_nxt = good_inc;
        if (desc_r) begin
          dsc_nxt = dsc_inc;
        end
      end else if (rpt_ok) begin
        good_nxt = '0;
        if (!seen_r) begin
          // first good report only sets the base
          seen_nxt = 1'b1;
          base_nxt = item.altitude_dm;
        end else begin
          if (!armed_r && (item.altitude_dm < base_r)) begin
            base_nxt = item.altitude_dm;
          end
          above    = {item.altitude_dm[23], item.altitude_dm} - {base_nxt[23], base_nxt};
          climb_ok = $signed({above[24], above}) >= $signed({6'b0, cfg.arm_gain_dm});
          if (!armed_r) begin
            if (climb_ok) begin
              armed_nxt = 1'b1;
              desc_nxt  = 1'b0;
            end
          end else if (climb_ok) begin
            desc_nxt = 1'b0;
          end else if (!desc_r) begin
            desc_nxt = 1'b1;
            dsc_nxt  = '0;
          end
        end
      end

      if (CW'(good_nxt) >= CW'(cfg.failsafe_seconds)) begin
        cause_nxt = adac_pkg::CAUSE_FAILSAFE;
      end
      // descent timeout wins over failsafe
      if (armed_nxt && desc_nxt && (CW'(dsc_nxt) >= CW'(cfg.descent_delay_seconds))) begin
        cause_nxt = adac_pkg::CAUSE_DESCENT;
      end

      if (cause_nxt == adac_pkg::CAUSE_NONE) begin
        if (armed_nxt && desc_nxt) begin
          rem_full = CW'(cfg.descent_delay_seconds) - CW'(dsc_nxt);
        end else begin
          rem_full = CW'(cfg.failsafe_seconds) - CW'(good_nxt);
        end
      end
    end
  end

  always_comb begin
    res.activated         = (cause_nxt != adac_pkg::CAUSE_NONE);
    res.activation_cause  = cause_nxt;
    res.armed             = armed_nxt;
    res.descending        = desc_nxt;
    res.secs_left         = rem_full[19:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= 1'b0;
      armed_r <= 1'b0;
      desc_r  <= 1'b0;
      base_r  <= '0;
      good_r  <= '0;
      dsc_r   <= '0;
      cause_r <= adac_pkg::CAUSE_NONE;
    end else if (step) begin
      seen_r  <= seen_nxt;
      armed_r <= armed_nxt;
      desc_r  <= desc_nxt;
      base_r  <= base_nxt;
      good_r  <= good_nxt;
      dsc_r   <= dsc_nxt;
      cause_r <= cause_nxt;
    end
  end

  a_cause_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (cause_r != adac_pkg::CAUSE_NONE) |=> (cause_r == $past(cause_r)))
    else $error("latched cause changed");

  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (cause_r != adac_pkg::CAUSE_NONE) |=>
      ($stable(good_r) && $stable(dsc_r) && $stable(base_r) && $stable(armed_r)))
    else $error("state moved after activation");

  a_desc_armed: assert property (@(posedge clk) disable iff (!rst_n)
    desc_r |-> (armed_r && seen_r))
    else $error("descent timer running while unarmed");

  a_cause_code: assert property (@(posedge clk) disable iff (!rst_n)
    (cause_r == adac_pkg::CAUSE_NONE) || (cause_r == adac_pkg::CAUSE_DESCENT) ||
    (cause_r == adac_pkg::CAUSE_FAILSAFE))
    else $error("undefined cause code");

endmodule
